### hdl/osc_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and checksum step functions for the secret checksum validator.
package osc_pkg;

    localparam int SECRET_MIN_BYTES = 26;
    localparam int KEY_BYTES        = 16;
    localparam int SEEN_W           = 5;
    localparam int PIN_W            = 5;
    localparam int CK_W             = 12;

    localparam logic [SEEN_W-1:0] SEEN_FULL = SEEN_W'(SECRET_MIN_BYTES);
    localparam logic [CK_W:0]     CK_POLY   = 13'h18F3;

    localparam logic [PIN_W-1:0] PIN_MIN_RST = 5'd4;
    localparam logic [PIN_W-1:0] PIN_MAX_RST = 5'd16;

    // Register indexes (byte address / 4)
    localparam logic REG_MIN_PIN = 1'b0;
    localparam logic REG_MAX_PIN = 1'b1;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_SHORT     = 2'd1,
        ST_MISMATCH  = 2'd2,
        ST_PIN_RANGE = 2'd3
    } t_status;

    typedef struct packed {
        logic [PIN_W-1:0] min_pin;
        logic [PIN_W-1:0] max_pin;
    } t_pin_cfg;

    // Eight remainder steps, MSB first; bit 12 never survives a step.
    function automatic logic [CK_W-1:0] ck_feed8(input logic [CK_W-1:0] rem,
                                                input logic [7:0]      data);
        logic [CK_W:0]   t;
        logic [CK_W-1:0] r;
        r = rem;
        for (int i = 7; i >= 0; i--) begin
            t = {r, data[i]};
            if (t[CK_W]) begin
                t = t ^ CK_POLY;
            end
            r = t[CK_W-1:0];
        end
        return r;
    endfunction

    // Four remainder steps for the top nibble of the penultimate byte.
    function automatic logic [CK_W-1:0] ck_feed4(input logic [CK_W-1:0] rem,
                                                input logic [3:0]      data);
        logic [CK_W:0]   t;
        logic [CK_W-1:0] r;
        r = rem;
        for (int i = 3; i >= 0; i--) begin
            t = {r, data[i]};
            if (t[CK_W]) begin
                t = t ^ CK_POLY;
            end
            r = t[CK_W-1:0];
        end
        return r;
    endfunction

endpackage

### hdl/otp_secret_checksum_validator.sv
`timescale 1ns / 1ps
// Top level: byte-stream checksum validator for a decoded one-time-password secret.
//
// Usage notes:
//  - Slave stream takes the decoded secret one byte per request, tlast on the
//    final byte. Master stream gives one result per secret, on its final byte.
//  - Bytes enter an input register; from there each byte updates the remainder,
//    tail window and byte count, and on tlast loads the result register, which
//    drives the master stream directly.
//  - Throughput: one byte per cycle, unless a final byte meets a full output register.
//    The remainder update is eight unrolled polynomial steps, plus four more on the final byte.
//  - Stall: a finished result waits in the output register; further non-final
//    bytes still flow. A final byte waits in the input register only while the
//    output register is full and not being taken.
//  - Reset (synchronous, active low) empties both registers, clears remainder
//    and byte count, and sets min/max PIN length to 4/16.
//  - APB: min_pin_length at 0x0, max_pin_length at 0x4; write only when idle.
//  - Result status: ok, too short (<26 bytes), checksum mismatch, PIN out of
//    range; the key (16 bytes starting 26 from the end) is zero unless ok.
module otp_secret_checksum_validator (
    input  logic          i_clk,
    input  logic          i_rst_n,
    // slave stream
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    input  logic [7:0]    i_s_tdata,   // [7:0] data_byte
    input  logic          i_s_tlast,   // last_byte
    // master stream
    output logic          o_m_tvalid,
    input  logic          i_m_tready,
    output logic [135:0]  o_m_tdata,   // [1:0] status, [6:2] pin_length,
                                       // [70:7] key_high, [134:71] key_low, [135] zero
    // APB config
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);
    import osc_pkg::*;

    localparam int HALF_KEY = KEY_BYTES / 2;

    t_pin_cfg cfg;

    osc_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // input register
    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_last;

    // secret state
    logic [CK_W-1:0]   r_rem;
    logic [SEEN_W-1:0] r_seen;
    logic [7:0]        r_win [0:SECRET_MIN_BYTES-1];   // newest at top index

    // result register
    logic              r_out_valid;
    t_status           r_status;
    logic [PIN_W-1:0]  r_pin;
    logic [63:0]       r_khi;
    logic [63:0]       r_klo;

    logic              out_free;
    logic              proc;
    logic              s_acc;

    logic [CK_W-1:0]   n_rem;
    logic [CK_W-1:0]   rem_fin;
    logic [CK_W-1:0]   stored;
    logic [SEEN_W-1:0] n_seen;
    logic [7:0]        penult;
    logic              full;
    t_status           n_status;
    logic [PIN_W-1:0]  dec_pin;
    logic [PIN_W-1:0]  n_pin;
    logic [63:0]       n_khi;
    logic [63:0]       n_klo;

    // handshake: a final byte needs room in the result register
    assign out_free   = !r_out_valid || i_m_tready;
    assign proc       = r_in_valid && (!r_in_last || out_free);
    assign o_s_tready = !r_in_valid || proc;
    assign s_acc      = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_acc) begin
            r_in_valid <= 1'b1;
        end else if (proc) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_in_byte <= i_s_tdata;
            r_in_last <= i_s_tlast;
        end
    end

    // datapath
    always_comb begin
        // byte two back is now known not to be among the checksum bytes
        n_rem   = (r_seen >= SEEN_W'(2)) ? ck_feed8(r_rem, r_win[SECRET_MIN_BYTES-2]) : r_rem;
        n_seen  = (r_seen == SEEN_FULL) ? SEEN_FULL : r_seen + SEEN_W'(1);
        full    = (n_seen == SEEN_FULL);
        penult  = r_win[SECRET_MIN_BYTES-1];
        rem_fin = ck_feed4(n_rem, penult[7:4]);
        stored  = {penult[3:0], r_in_byte};
        dec_pin = {1'b0, penult[7:4]} + PIN_W'(1);

        if (!full) begin
            n_status = ST_SHORT;
            n_pin    = '0;
        end else if (rem_fin != stored) begin
            n_status = ST_MISMATCH;
            n_pin    = dec_pin;
        end else if (dec_pin < cfg.min_pin || dec_pin > cfg.max_pin) begin
            n_status = ST_PIN_RANGE;
            n_pin    = dec_pin;
        end else begin
            n_status = ST_OK;
            n_pin    = dec_pin;
        end

        // key = post-shift window bytes 0..15, i.e. current bytes 1..16
        n_khi = '0;
        n_klo = '0;
        for (int i = 0; i < HALF_KEY; i++) begin
            n_khi[63-8*i -: 8] = r_win[1+i];
            n_klo[63-8*i -: 8] = r_win[1+HALF_KEY+i];
        end
        if (n_status != ST_OK) begin
            n_khi = '0;
            n_klo = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem  <= '0;
            r_seen <= '0;
        end else if (proc) begin
            if (r_in_last) begin
                r_rem  <= '0;
                r_seen <= '0;
            end else begin
                r_rem  <= n_rem;
                r_seen <= n_seen;
            end
        end
    end

    // tail window; stale bytes are never read before the count covers them
    always_ff @(posedge i_clk) begin
        if (proc) begin
            for (int i = 0; i < SECRET_MIN_BYTES-1; i++) begin
                r_win[i] <= r_win[i+1];
            end
            r_win[SECRET_MIN_BYTES-1] <= r_in_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc && r_in_last) begin
            r_status <= n_status;
            r_pin    <= n_pin;
            r_khi    <= n_khi;
            r_klo    <= n_klo;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {1'b0, r_klo, r_khi, r_pin, r_status};

endmodule

### hdl/osc_cfg_regs.sv
`timescale 1ns / 1ps
// APB register file holding the PIN length limits.
module osc_cfg_regs (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output osc_pkg::t_pin_cfg   o_cfg
);
    import osc_pkg::*;

    logic [PIN_W-1:0] r_min_pin;
    logic [PIN_W-1:0] r_max_pin;
    logic             wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_pin <= PIN_MIN_RST;
            r_max_pin <= PIN_MAX_RST;
        end else if (wr_en) begin
            case (paddr[2])
                REG_MIN_PIN: r_min_pin <= pwdata[PIN_W-1:0];
                REG_MAX_PIN: r_max_pin <= pwdata[PIN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_MIN_PIN: prdata = {{(32-PIN_W){1'b0}}, r_min_pin};
            REG_MAX_PIN: prdata = {{(32-PIN_W){1'b0}}, r_max_pin};
            default:     prdata = '0;
        endcase
    end

    assign o_cfg.min_pin = r_min_pin;
    assign o_cfg.max_pin = r_max_pin;

endmodule
